// ----- hdl/adc_sample_condition_filter_macros.svh -----
// Assertion macros for the ADC sample conditioning filter checker.
// Used by files that hold concurrent assertions; no other dependencies.
`ifndef ADC_SAMPLE_CONDITION_FILTER_MACROS_SVH
`define ADC_SAMPLE_CONDITION_FILTER_MACROS_SVH

// Overlapping implication, sampled on clk_i, off during reset.
`define ASC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked on the following clock edge.
`define ASC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/asc_pkg.sv -----
// Shared types, constants and conversion law table for the ADC conditioning filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package asc_pkg;

  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 25;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Reciprocal scale: q0 = (n * floor(2^32 / d)) >> 32, then one correction step.
  localparam int unsigned RCP_SHIFT = 32;

  localparam logic [15:0]        DIV_FILT = 16'd255;
  localparam logic [MUL_B_W-1:0] RCP_FILT = 25'd16843009;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WEIGHT = 2'd1,
    REG_UPPER  = 2'd2,
    REG_LOWER  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_TEMP   = 2'd0,
    MODE_BATT   = 2'd1,
    MODE_CURR   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LAW,
    ST_ABS_LAW,
    ST_MUL_RCP,
    ST_MUL_BACK,
    ST_FIX,
    ST_SAT,
    ST_DIFF,
    ST_MUL_K,
    ST_SUM,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  weight;
    logic [15:0] upper;
    logic [15:0] lower;
  } cfg_t;

  // Linear law: n = offs - coef*r (sub) or coef*r, then n / divisor.
  typedef struct packed {
    logic [31:0]        offs;
    logic [MUL_B_W-1:0] coef;
    logic [15:0]        divisor;
    logic [MUL_B_W-1:0] rcp;
    logic               sub;
  } law_t;

  function automatic law_t law_of(mode_e mode);
    law_t law;
    unique case (mode)
      MODE_TEMP: law = '{offs: 32'd407998500, coef: 25'd220000, divisor: 16'd11739,
                         rcp: 25'd365871, sub: 1'b1};
      MODE_BATT: law = '{offs: 32'd0, coef: 25'd5060, divisor: 16'd819,
                         rcp: 25'd5244160, sub: 1'b0};
      MODE_CURR: law = '{offs: 32'd2384452980, coef: 25'd1169520, divisor: 16'd40950,
                         rcp: 25'd104883, sub: 1'b1};
      default:   law = '{offs: 32'd0, coef: 25'd0, divisor: DIV_FILT,
                         rcp: RCP_FILT, sub: 1'b1};
    endcase
    return law;
  endfunction

endpackage

// ----- hdl/asc_mul_unit.sv -----
// Shared unsigned multiplier with registered product for the conditioning filter.
// Depends on asc_pkg for operand widths.
`timescale 1ns / 1ps

module asc_mul_unit (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [asc_pkg::MUL_A_W-1:0] a_i,
  input  logic [asc_pkg::MUL_B_W-1:0] b_i,
  output logic [asc_pkg::MUL_P_W-1:0] p_o
);
  import asc_pkg::*;

  logic [MUL_P_W-1:0] p_q;
  logic [MUL_P_W-1:0] p_d;

  assign p_d = {{MUL_B_W{1'b0}}, a_i} * {{MUL_A_W{1'b0}}, b_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- hdl/asc_cfg_regs.sv -----
// APB-style configuration registers of the conditioning filter.
// Depends on asc_pkg for the register index codes and the cfg_t struct.
`timescale 1ns / 1ps

module asc_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output asc_pkg::cfg_t cfg_o
);
  import asc_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_MODE:   cfg_d.mode   = pwdata[1:0];
        REG_WEIGHT: cfg_d.weight = pwdata[7:0];
        REG_UPPER:  cfg_d.upper  = pwdata[15:0];
        REG_LOWER:  cfg_d.lower  = pwdata[15:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = {30'd0, cfg_q.mode};
      REG_WEIGHT: prdata = {24'd0, cfg_q.weight};
      REG_UPPER:  prdata = {16'd0, cfg_q.upper};
      REG_LOWER:  prdata = {16'd0, cfg_q.lower};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: 2'd0, weight: 8'd0, upper: 16'hFFFF, lower: 16'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/asc_core.sv -----
// Sequencer and datapath of the conditioning filter: law, exact division by
// reciprocal plus correction, smoothing and limit check on one shared multiplier.
// Depends on asc_pkg and asc_mul_unit.
`timescale 1ns / 1ps

module asc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  asc_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [11:0]        raw_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] converted_value_o,
  output logic signed [15:0] filtered_value_o,
  output logic               out_of_range_o,
  output logic               fault_latched_o
);
  import asc_pkg::*;

  st_e st_q, st_d;
  logic phase_q, phase_d;   // 0: law division, 1: smoothing division
  logic out_valid_q, out_valid_d;
  logic fault_q, fault_d;
  logic signed [15:0] y_q, y_d;

  logic [11:0]        r_q, r_d;
  logic [31:0]        n_q, n_d;
  logic               neg_q, neg_d;
  logic [16:0]        q_q, q_d;
  logic signed [15:0] x_q, x_d;
  logic signed [15:0] cv_q, cv_d;
  logic signed [15:0] fv_q, fv_d;
  logic               oor_q, oor_d;
  logic               flt_q, flt_d;

  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  law_t               law;
  logic [15:0]        div;
  logic [MUL_B_W-1:0] rcp;
  logic [16:0]        q0;
  logic signed [33:0] num;
  logic signed [33:0] num_abs;
  logic [31:0]        rem;
  logic signed [17:0] qs;
  logic signed [16:0] diff;
  logic signed [16:0] diff_abs;
  logic signed [25:0] x_ext;
  logic signed [25:0] x255;
  logic signed [25:0] kp;
  logic signed [25:0] sum;
  logic signed [25:0] sum_abs;
  logic               oor;

  asc_mul_unit u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign law = law_of(mode_e'(cfg_i.mode));
  assign div = phase_q ? DIV_FILT : law.divisor;
  assign rcp = phase_q ? RCP_FILT : law.rcp;
  assign q0  = prod[RCP_SHIFT+16:RCP_SHIFT];

  assign num = law.sub ? ($signed({2'b00, law.offs}) - $signed({1'b0, prod[32:0]}))
                       : $signed({1'b0, prod[32:0]});
  assign num_abs = num[33] ? -num : num;
  assign rem     = n_q - prod[31:0];
  assign qs      = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});

  assign diff     = $signed({y_q[15], y_q}) - $signed({x_q[15], x_q});
  assign diff_abs = diff[16] ? -diff : diff;

  assign x_ext   = {{10{x_q[15]}}, x_q};
  assign x255    = (x_ext <<< 8) - x_ext;
  assign kp      = $signed({2'b00, prod[23:0]});
  assign sum     = neg_q ? (x255 - kp) : (x255 + kp);
  assign sum_abs = sum[25] ? -sum : sum;

  assign oor = (qs >= $signed({2'b00, cfg_i.upper})) || (qs <= $signed({2'b00, cfg_i.lower}));

  always_comb begin
    st_d        = st_q;
    phase_d     = phase_q;
    fault_d     = fault_q;
    y_d         = y_q;
    r_d         = r_q;
    n_d         = n_q;
    neg_d       = neg_q;
    q_d         = q_q;
    x_d         = x_q;
    cv_d        = cv_q;
    fv_d        = fv_q;
    oor_d       = oor_q;
    flt_d       = flt_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (st_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          r_d     = raw_sample_i;
          phase_d = 1'b0;
          st_d    = ST_MUL_LAW;
        end
      end
      ST_MUL_LAW: begin
        mul_en = 1'b1;
        mul_a  = {20'd0, r_q};
        mul_b  = law.coef;
        st_d   = ST_ABS_LAW;
      end
      ST_ABS_LAW: begin
        n_d   = num_abs[31:0];
        neg_d = num[33];
        st_d  = ST_MUL_RCP;
      end
      ST_MUL_RCP: begin
        mul_en = 1'b1;
        mul_a  = n_q;
        mul_b  = rcp;
        st_d   = ST_MUL_BACK;
      end
      ST_MUL_BACK: begin
        // Multiply the estimate back to get the remainder.
        mul_en = 1'b1;
        mul_a  = {15'd0, q0};
        mul_b  = {9'd0, div};
        q_d    = q0;
        st_d   = ST_FIX;
      end
      ST_FIX: begin
        if (rem >= {16'd0, div}) begin
          q_d = q_q + 17'd1;
        end
        st_d = phase_q ? ST_DONE : ST_SAT;
      end
      ST_SAT: begin
        if (qs > 18'sd32767) begin
          x_d = 16'sh7FFF;
        end else if (qs < -18'sd32768) begin
          x_d = 16'sh8000;
        end else begin
          x_d = qs[15:0];
        end
        st_d = ST_DIFF;
      end
      ST_DIFF: begin
        n_d   = {16'd0, diff_abs[15:0]};
        neg_d = diff[16];
        st_d  = ST_MUL_K;
      end
      ST_MUL_K: begin
        mul_en = 1'b1;
        mul_a  = {16'd0, n_q[15:0]};
        mul_b  = {17'd0, cfg_i.weight};
        st_d   = ST_SUM;
      end
      ST_SUM: begin
        // 255*x + k*(y_prev - x) equals (255-k)*x + k*y_prev.
        n_d     = {8'd0, sum_abs[23:0]};
        neg_d   = sum[25];
        phase_d = 1'b1;
        st_d    = ST_MUL_RCP;
      end
      ST_DONE: begin
        // Hold until the output slot is free.
        if (!out_valid_q || !out_stall_i) begin
          cv_d        = x_q;
          fv_d        = qs[15:0];
          oor_d       = oor;
          flt_d       = fault_q || oor;
          y_d         = qs[15:0];
          fault_d     = fault_q || oor;
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      fault_q     <= 1'b0;
      y_q         <= 16'sd0;
    end else begin
      st_q        <= st_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      fault_q     <= fault_d;
      y_q         <= y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    n_q   <= n_d;
    neg_q <= neg_d;
    q_q   <= q_d;
    x_q   <= x_d;
    cv_q  <= cv_d;
    fv_q  <= fv_d;
    oor_q <= oor_d;
    flt_q <= flt_d;
  end

  assign out_valid_o       = out_valid_q;
  assign converted_value_o = cv_q;
  assign filtered_value_o  = fv_q;
  assign out_of_range_o    = oor_q;
  assign fault_latched_o   = flt_q;

endmodule

// ----- hdl/adc_sample_condition_filter.sv -----
// ADC sample conditioning filter: a 12-bit reading goes through the selected linear
// law (chip temperature in 0.01 degC, battery mV, or current in 0.1 mA), truncated
// toward zero and saturated to int16, then through an exponential moving average
// with weight k/255 on the previous value, and a limit check with a sticky fault.
// A sample is accepted only while the sequencer is idle; it then walks a single
// shared multiplier through six products (the law, two for each of the two exact
// divisions by reciprocal with a remainder fix, and the smoothing weight). The
// result sits in an output register, so a new sample is taken while it waits.
// Configure the registers only while no sample is in flight.
// Depends on asc_pkg, asc_cfg_regs, asc_core.
`timescale 1ns / 1ps

module adc_sample_condition_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [11:0]        raw_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] converted_value_o,
  output logic signed [15:0] filtered_value_o,
  output logic               out_of_range_o,
  output logic               fault_latched_o
);
  import asc_pkg::*;

  cfg_t cfg;

  asc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  asc_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .raw_sample_i      (raw_sample_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .converted_value_o (converted_value_o),
    .filtered_value_o  (filtered_value_o),
    .out_of_range_o    (out_of_range_o),
    .fault_latched_o   (fault_latched_o)
  );

endmodule

// ----- hdl/asc_checker.sv -----
// Port-level checker for the ADC conditioning filter, bound to the top level.
// Depends on adc_sample_condition_filter_macros.svh.
`timescale 1ns / 1ps
`include "adc_sample_condition_filter_macros.svh"

module asc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] filtered_value_o,
  input logic               out_of_range_o,
  input logic               fault_latched_o
);

  // A taken sample keeps the block busy in the following cycle.
  `ASC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // An out-of-range result always reports the fault.
  `ASC_ASSERT_IMPL(a_oor_sets_fault, out_valid_o && out_of_range_o, fault_latched_o)

  // Once reported, the fault stays on every later result.
  `ASC_ASSERT_NEXT(a_fault_sticky, out_valid_o && !out_stall_i && fault_latched_o,
                   !out_valid_o || fault_latched_o)

  // Hold a stalled result.
  `ASC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(filtered_value_o))

endmodule

bind adc_sample_condition_filter asc_checker u_asc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .filtered_value_o (filtered_value_o),
  .out_of_range_o   (out_of_range_o),
  .fault_latched_o  (fault_latched_o)
);

// ----- tb/sv/adc_sample_condition_filter_tb.sv -----
// Self-checking testbench for the ADC sample conditioning filter: directed and random
// samples through all conversion laws, smoothing weights and limits, checked against
// an in-bench predictor. Depends on asc_pkg and adc_sample_condition_filter.
`timescale 1ns / 1ps

module adc_sample_condition_filter_tb;
  import asc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_GAP       = 17;

  typedef struct {
    logic signed [15:0] converted;
    logic signed [15:0] filtered;
    logic               out_of_range;
    logic               fault;
  } sample_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [11:0]        raw_sample_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] converted_value_o;
  logic signed [15:0] filtered_value_o;
  logic               out_of_range_o;
  logic               fault_latched_o;

  adc_sample_condition_filter uut (.*);

  // Predictor copy of configuration and state
  logic [1:0]         cfg_mode;
  logic [7:0]         cfg_weight;
  logic [15:0]        cfg_upper;
  logic [15:0]        cfg_lower;
  logic signed [15:0] model_smoothed;
  logic               model_fault;

  sample_result_t pending_results[$];
  int             error_count;
  int             cycle_count;
  int             hold_request;
  bit             tx_idle_on;
  bit             rx_idle_on;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Convert, smooth and limit-check one sample; advances the predictor state.
  function automatic sample_result_t condition_sample(logic [11:0] r);
    sample_result_t res;
    longint rl;
    longint n;
    int     x;
    int     k;
    int     prev;
    int     y;
    int     up;
    int     lo;
    rl = longint'(r);
    case (mode_e'(cfg_mode))
      MODE_TEMP: n = (64'sd407998500 - 64'sd220000 * rl) / 64'sd11739;
      MODE_BATT: n = (64'sd5060 * rl) / 64'sd819;
      MODE_CURR: n = (64'sd2384452980 - 64'sd1169520 * rl) / 64'sd40950;
      default:   n = 0;
    endcase
    if (n > 32767) x = 32767;
    else if (n < -32768) x = -32768;
    else x = int'(n);
    k    = int'(cfg_weight);
    prev = int'(model_smoothed);
    y    = ((255 - k) * x + k * prev) / 255;
    up   = int'(cfg_upper);
    lo   = int'(cfg_lower);
    res.converted    = x[15:0];
    res.filtered     = y[15:0];
    res.out_of_range = (y >= up) || (y <= lo);
    model_smoothed   = y[15:0];
    if (res.out_of_range) model_fault = 1'b1;
    res.fault = model_fault;
    return res;
  endfunction

  // One APB transfer: setup, access, then back to idle.
  task automatic apb_transfer(input logic wr, input reg_idx_e idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] word);
    logic [31:0] rd;
    logic [31:0] want;
    apb_transfer(1'b1, idx, word, rd);
    case (idx)
      REG_MODE:   cfg_mode   = word[1:0];
      REG_WEIGHT: cfg_weight = word[7:0];
      REG_UPPER:  cfg_upper  = word[15:0];
      REG_LOWER:  cfg_lower  = word[15:0];
    endcase
    apb_transfer(1'b0, idx, 32'd0, rd);
    case (idx)
      REG_MODE:   want = {30'd0, cfg_mode};
      REG_WEIGHT: want = {24'd0, cfg_weight};
      REG_UPPER:  want = {16'd0, cfg_upper};
      default:    want = {16'd0, cfg_lower};
    endcase
    if (rd !== want) begin
      $error("prdata[%s] expected %0h got %0h", idx.name(), want, rd);
      error_count++;
    end
  endtask

  // Write all registers; bits above each field carry noise and must be dropped.
  task automatic set_config(input logic [1:0] mode, input logic [7:0] weight,
                            input logic [15:0] upper, input logic [15:0] lower);
    logic [31:0] w;
    w = $urandom(); w[1:0]  = mode;   write_reg(REG_MODE, w);
    w = $urandom(); w[7:0]  = weight; write_reg(REG_WEIGHT, w);
    w = $urandom(); w[15:0] = upper;  write_reg(REG_UPPER, w);
    w = $urandom(); w[15:0] = lower;  write_reg(REG_LOWER, w);
  endtask

  task automatic send_sample(input logic [11:0] r);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= r;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_results.push_back(condition_sample(r));
  endtask

  // Drop valid, wait for every outstanding result, then let the sequencer settle.
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    logic [31:0] rd;
    apb_transfer(1'b0, REG_MODE, 32'd0, rd);
    if (rd !== 32'd0) begin $error("mode reset expected 0 got %0h", rd); error_count++; end
    apb_transfer(1'b0, REG_WEIGHT, 32'd0, rd);
    if (rd !== 32'd0) begin $error("weight reset expected 0 got %0h", rd); error_count++; end
    apb_transfer(1'b0, REG_UPPER, 32'd0, rd);
    if (rd !== 32'hFFFF) begin $error("upper reset expected ffff got %0h", rd); error_count++; end
    apb_transfer(1'b0, REG_LOWER, 32'd0, rd);
    if (rd !== 32'd0) begin $error("lower reset expected 0 got %0h", rd); error_count++; end
    // in range first so the fault flag is seen clear, then a saturated low reading
    send_sample(12'd0);
    send_sample(12'd1);
    send_sample(12'd4095);
    drain_pipeline();
  endtask

  task automatic test_conversion_modes();
    set_config(MODE_BATT, 8'd0, 16'hFFFF, 16'd0);
    send_sample(12'd0);
    send_sample(12'd819);
    send_sample(12'd4095);
    drain_pipeline();
    set_config(MODE_CURR, 8'd0, 16'hFFFF, 16'd0);
    send_sample(12'd0);
    send_sample(12'd2048);
    send_sample(12'd4095);
    drain_pipeline();
    set_config(MODE_UNUSED, 8'd0, 16'hFFFF, 16'd0);
    send_sample(12'd4095);
    drain_pipeline();
    set_config(MODE_TEMP, 8'd0, 16'hFFFF, 16'd0);
    send_sample(12'd2048);
    drain_pipeline();
  endtask

  task automatic test_smoothing_extremes();
    set_config(MODE_BATT, 8'd255, 16'hFFFF, 16'd0);
    send_sample(12'd4095);
    send_sample(12'd0);
    drain_pipeline();
    set_config(MODE_BATT, 8'd128, 16'hFFFF, 16'd0);
    send_sample(12'd4095);
    send_sample(12'd1234);
    send_sample(12'd0);
    drain_pipeline();
  endtask

  // Battery law at reading 819 gives exactly 5060; walk the limits across it.
  task automatic test_limit_edges();
    set_config(MODE_BATT, 8'd0, 16'd5060, 16'd0);
    send_sample(12'd819);
    drain_pipeline();
    set_config(MODE_BATT, 8'd0, 16'd5061, 16'd5059);
    send_sample(12'd819);
    drain_pipeline();
    set_config(MODE_BATT, 8'd0, 16'd5061, 16'd5060);
    send_sample(12'd819);
    drain_pipeline();
    set_config(MODE_CURR, 8'd0, 16'd0, 16'hFFFF);
    send_sample(12'd4095);
    drain_pipeline();
  endtask

  task automatic test_random_phases();
    logic [7:0]  weight;
    logic [15:0] upper;
    logic [15:0] lower;
    logic [11:0] r;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 3))
        0:       weight = 8'd0;
        1:       weight = 8'd255;
        default: weight = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 3))
        0:       begin upper = 16'hFFFF; lower = 16'd0; end
        1:       begin upper = 16'd0;    lower = 16'hFFFF; end
        default: begin
          upper = 16'($urandom_range(0, 65535));
          lower = 16'($urandom_range(0, 20000));
        end
      endcase
      set_config(2'($urandom_range(0, 3)), weight, upper, lower);
      tx_idle_on = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      rx_idle_on = (phase == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      for (int i = 0; i < 48; i++) begin
        case ($urandom_range(0, 9))
          0:       r = 12'd0;
          1:       r = 12'd4095;
          default: r = 12'($urandom_range(0, 4095));
        endcase
        send_sample(r);
      end
      drain_pipeline();
    end
  endtask

  // Receiver holds off while the sender keeps offering; input must back up.
  task automatic test_backpressure();
    set_config(MODE_TEMP, 8'd200, 16'd30000, 16'd100);
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    hold_request = 400;
    repeat (24) send_sample(12'($urandom_range(0, 4095)));
    drain_pipeline();
  endtask

  // Result checker and receiver stall generator
  initial begin
    int             rx_wait;
    int             hold_left;
    sample_result_t want;
    rx_wait   = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no expectation pending");
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (converted_value_o !== want.converted) begin
            $error("converted_value expected %0d got %0d", want.converted, converted_value_o);
            error_count++;
          end
          if (filtered_value_o !== want.filtered) begin
            $error("filtered_value expected %0d got %0d", want.filtered, filtered_value_o);
            error_count++;
          end
          if (out_of_range_o !== want.out_of_range) begin
            $error("out_of_range expected %0b got %0b", want.out_of_range, out_of_range_o);
            error_count++;
          end
          if (fault_latched_o !== want.fault) begin
            $error("fault_latched expected %0b got %0b", want.fault, fault_latched_o);
            error_count++;
          end
        end
        rx_wait = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("adc_sample_condition_filter_tb: FAIL");
    $finish;
  end

  initial begin
    error_count    = 0;
    hold_request   = 0;
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    cfg_mode       = MODE_TEMP;
    cfg_weight     = 8'd0;
    cfg_upper      = 16'hFFFF;
    cfg_lower      = 16'd0;
    model_smoothed = '0;
    model_fault    = 1'b0;
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid_i   <= 1'b0;
    raw_sample_i <= '0;
    out_stall_i  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_conversion_modes();
    test_smoothing_extremes();
    test_limit_edges();
    test_random_phases();
    test_backpressure();

    drain_pipeline();
    if (error_count == 0) begin
      $display("adc_sample_condition_filter_tb: PASS");
    end else begin
      $display("adc_sample_condition_filter_tb: FAIL");
    end
    $finish;
  end

endmodule
